// ----- design/ifdr_pkg.sv -----
package ifdr_pkg;

  // Input item kinds.
  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_FETCH = 1'b1
  } kind_e;

  // Result item kinds.
  typedef enum logic {
    RES_SUMMARY = 1'b0,
    RES_PIXEL   = 1'b1
  } res_kind_e;

  // Configuration register indexes.
  localparam logic [1:0] REG_DIFF_ENABLE  = 2'd0;
  localparam logic [1:0] REG_TRANSPARENT  = 2'd1;
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd2;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd3;

  localparam int unsigned CountW   = 19;
  localparam int unsigned IndexW   = 8;
  localparam int unsigned NumIndex = 256;

  // Summary fields latched at frame end and repeated on pixel results.
  typedef struct packed {
    logic [8:0] left;
    logic [8:0] top;
    logic [9:0] width;
    logic [9:0] height;
    logic       changed;
    logic       trans;
    logic [7:0] tidx;
  } summary_t;

endpackage

// ----- design/ifdr_argmin.sv -----
// Sequential scan over the usage counts: one entry per cycle, keeping the
// lowest index on ties. The counts memory is owned here so the scan can
// also clear each entry as it passes.
module ifdr_argmin #(
  parameter int unsigned PaletteSize = 256
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Count increment from the load path.
  input  logic                     inc_i,
  input  logic [ifdr_pkg::IndexW-1:0] inc_idx_i,
  // Start a scan-and-clear pass.
  input  logic                     scan_i,
  // Clear-only pass (size change).
  input  logic                     clear_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [ifdr_pkg::IndexW-1:0] best_o
);
  import ifdr_pkg::*;

  logic [CountW-1:0] cnt_mem [NumIndex];

  // Increment pipeline: read, then write back with forwarding.
  logic              inc_q;
  logic [IndexW-1:0] inc_idx_q;
  logic [CountW-1:0] rd_q;
  logic [CountW-1:0] cur_cnt;
  logic [CountW-1:0] new_cnt;
  logic              fwd_q;
  logic [CountW-1:0] fwd_val_q;
  logic [IndexW-1:0] rd_addr;

  // Scan state.
  logic              scan_on_q, clr_on_q, do_min_q, rd_valid_q, last_q;
  logic [8:0]        ptr_q;
  logic [IndexW-1:0] rd_idx_q;
  logic [CountW-1:0] min_q;
  logic [IndexW-1:0] best_q;
  logic              have_q;
  logic              done_q;

  assign cur_cnt = fwd_q ? fwd_val_q : rd_q;
  assign new_cnt = (cur_cnt == {CountW{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;
  assign rd_addr = (scan_on_q || clr_on_q) ? ptr_q[7:0] : inc_idx_i;

  // Memory port: increments write, scan writes zero behind its read. A read of
  // the entry being written back takes the new count.
  always_ff @(posedge clk_i) begin
    rd_q <= (inc_q && rd_addr == inc_idx_q) ? new_cnt : cnt_mem[rd_addr];
    if (inc_q) begin
      cnt_mem[inc_idx_q] <= new_cnt;
    end else if (rd_valid_q) begin
      cnt_mem[rd_idx_q] <= '0;
    end
  end

  // Control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q      <= 1'b0;
      inc_idx_q  <= '0;
      fwd_q      <= 1'b0;
      fwd_val_q  <= '0;
      scan_on_q  <= 1'b0;
      clr_on_q   <= 1'b1;
      do_min_q   <= 1'b0;
      rd_valid_q <= 1'b0;
      last_q     <= 1'b0;
      ptr_q      <= '0;
      rd_idx_q   <= '0;
      min_q      <= '1;
      best_q     <= '0;
      have_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      inc_q     <= inc_i;
      inc_idx_q <= inc_idx_i;
      fwd_q     <= inc_i && inc_q && (inc_idx_i == inc_idx_q);
      fwd_val_q <= new_cnt;
      rd_valid_q <= scan_on_q || clr_on_q;
      rd_idx_q   <= ptr_q[7:0];
      do_min_q   <= scan_on_q && (ptr_q < 9'(PaletteSize));
      last_q     <= (scan_on_q || clr_on_q) && (ptr_q == 9'(NumIndex - 1));
      if (scan_i || clear_i) begin
        scan_on_q <= scan_i;
        clr_on_q  <= clear_i;
        ptr_q     <= '0;
        min_q     <= '1;
        best_q    <= '0;
        have_q    <= 1'b0;
      end else if (scan_on_q || clr_on_q) begin
        ptr_q <= ptr_q + 1'b1;
        if (ptr_q == 9'(NumIndex - 1)) begin
          scan_on_q <= 1'b0;
          clr_on_q  <= 1'b0;
        end
      end
      if (do_min_q && (!have_q || rd_q < min_q)) begin
        min_q  <= rd_q;
        best_q <= rd_idx_q;
        have_q <= 1'b1;
      end
      // Done stays up until the next pass starts.
      if (scan_i || clear_i) begin
        done_q <= 1'b0;
      end else if (last_q) begin
        done_q <= 1'b1;
      end
    end
  end

  assign busy_o = scan_on_q || clr_on_q || rd_valid_q;
  assign done_o = done_q;
  assign best_o = best_q;

  a_no_inc_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_on_q || clr_on_q) |-> !inc_i) else $error("count update during scan");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !scan_on_q && !clr_on_q) else $error("scan done while running");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_on_q || clr_on_q) |-> ptr_q < 9'(NumIndex)) else $error("scan pointer overrun");
endmodule

// ----- design/indexed_frame_delta_region.sv -----
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] pixel_index, tuser kind
// m_axis    out        tdata: see port comment, tuser result_kind, tlast last_pixel
// cfg       in         cfg_we_i, cfg_idx_i, cfg_data_i[9:0]
//
// A load passes through transfer with memory read, then compare and write
// back; a fetch passes through transfer, address, memory read and result. An
// ignored item is dropped at transfer. The frame store port sets these steps.
// After the last load of a frame the 256-entry usage scan runs before the
// summary appears; a clear-only pass over the counts runs after reset and after
// a size change, while no item is taken. A result waiting to be taken holds a
// fetch in its result cycle and the summary at frame end; loads are not held.
module indexed_frame_delta_region #(
  parameter int unsigned MAX_WIDTH    = 512,
  parameter int unsigned MAX_HEIGHT   = 512,
  parameter int unsigned PALETTE_SIZE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_index
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [8:0] region_left, [17:9] region_top, [27:18] region_width,
  // [37:28] region_height, [38] frame_changed, [39] transparency_on,
  // [47:40] transparent_index, [55:48] pixel_value
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tuser,   // result_kind
  output logic        m_axis_tlast,   // last_pixel
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  import ifdr_pkg::*;

  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PW    = $clog2(Depth + 1);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOAD, ST_SCAN, ST_FADDR, ST_FREAD, ST_FOUT, ST_CLEAR
  } state_e;

  // Frame store: two banks as one memory, bank bit on top of the address.
  logic [7:0] store_mem [2 * Depth];
  logic [7:0] cur_rd_q, prev_rd_q;

  state_e      state_q;
  logic        diff_en_q, trans_en_q;
  logic [XW-1:0] fw_q;
  logic [YW-1:0] fh_q;
  logic        bank_q, prev_valid_q, any_q, pend_q;
  logic [PW-1:0] lpos_q;
  logic [XW-1:0] lx_q;
  logic [YW-1:0] ly_q;
  logic [XW-1:0] minx_q, maxx_q;
  logic [YW-1:0] miny_q, maxy_q;
  logic [7:0]  px_q;
  summary_t    sum_q;
  logic [XW-1:0] sfw_q;
  // Emission walk.
  logic [XW-1:0] ex_q;
  logic [YW-1:0] ey_q;
  logic [AW-1:0] eaddr_q;
  logic          elast_q;
  logic          ovalid_q;
  logic [55:0]   odata_q;
  logic          ouser_q, olast_q;

  logic [XW-1:0] wclamp;
  logic [YW-1:0] hclamp;
  logic          size_chg;
  logic          acc;
  logic [AW-1:0] rd_addr;
  logic          sc_busy, sc_done, sc_scan, sc_clear;
  logic [7:0]    sc_best;
  logic          inc;
  logic          out_free;
  logic [PW-1:0] total;

  assign wclamp = (cfg_data_i == 10'd0) ? XW'(1) :
                  ({22'd0, cfg_data_i} > 32'(MAX_WIDTH)) ? XW'(MAX_WIDTH) :
                  XW'(cfg_data_i);
  assign hclamp = (cfg_data_i == 10'd0) ? YW'(1) :
                  ({22'd0, cfg_data_i} > 32'(MAX_HEIGHT)) ? YW'(MAX_HEIGHT) :
                  YW'(cfg_data_i);
  assign size_chg = cfg_we_i &&
    ((cfg_idx_i == REG_FRAME_WIDTH && wclamp != fw_q) ||
     (cfg_idx_i == REG_FRAME_HEIGHT && hclamp != fh_q));

  assign out_free = !ovalid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !size_chg;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign total = PW'(fw_q * fh_q);

  // Load reads at its position; fetch reads at the emission address until
  // its result is out.
  assign rd_addr = (state_q == ST_FADDR || state_q == ST_FREAD || state_q == ST_FOUT) ?
                   eaddr_q : AW'(lpos_q);

  always_ff @(posedge clk_i) begin
    cur_rd_q  <= store_mem[{bank_q, rd_addr}];
    prev_rd_q <= store_mem[{~bank_q, rd_addr}];
    if (state_q == ST_LOAD) store_mem[{bank_q, AW'(lpos_q)}] <= px_q;
  end

  assign inc = (state_q == ST_LOAD);

  ifdr_argmin #(.PaletteSize(PALETTE_SIZE)) u_argmin (
    .clk_i, .rst_ni,
    .inc_i(inc), .inc_idx_i(px_q),
    .scan_i(sc_scan), .clear_i(sc_clear),
    .busy_o(sc_busy), .done_o(sc_done), .best_o(sc_best)
  );

  assign sc_scan  = (state_q == ST_LOAD) && (lpos_q + 1'b1 >= total);
  assign sc_clear = size_chg;

  // Sequencer, registers and output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      diff_en_q <= 1'b0; trans_en_q <= 1'b0;
      fw_q <= XW'(MAX_WIDTH); fh_q <= YW'(MAX_HEIGHT);
      bank_q <= 1'b0; prev_valid_q <= 1'b0; any_q <= 1'b0; pend_q <= 1'b0;
      lpos_q <= '0; lx_q <= '0; ly_q <= '0;
      minx_q <= XW'(MAX_WIDTH); maxx_q <= '0;
      miny_q <= YW'(MAX_HEIGHT); maxy_q <= '0;
      px_q <= '0;
      sum_q <= '{left: '0, top: '0, width: 10'(MAX_WIDTH), height: 10'(MAX_HEIGHT),
                 changed: 1'b0, trans: 1'b0, tidx: '0};
      sfw_q <= XW'(MAX_WIDTH);
      ex_q <= '0; ey_q <= '0; eaddr_q <= '0; elast_q <= 1'b0;
      ovalid_q <= 1'b0; odata_q <= '0; ouser_q <= 1'b0; olast_q <= 1'b0;
    end else begin
      if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DIFF_ENABLE:  diff_en_q  <= cfg_data_i[0];
          REG_TRANSPARENT:  trans_en_q <= cfg_data_i[0];
          REG_FRAME_WIDTH:  fw_q <= wclamp;
          REG_FRAME_HEIGHT: fh_q <= hclamp;
          default: ;
        endcase
        if (size_chg) begin
          prev_valid_q <= 1'b0;
          lpos_q <= '0; lx_q <= '0; ly_q <= '0;
          minx_q <= (cfg_idx_i == REG_FRAME_WIDTH) ? wclamp : fw_q;
          miny_q <= (cfg_idx_i == REG_FRAME_HEIGHT) ? hclamp : fh_q;
          maxx_q <= '0; maxy_q <= '0; any_q <= 1'b0;
          state_q <= ST_CLEAR;
        end
      end
      unique case (state_q)
        ST_CLEAR: if (!sc_busy && !size_chg) state_q <= ST_IDLE;
        ST_IDLE: if (acc) begin
          if (s_axis_tuser == KIND_LOAD && !pend_q) begin
            px_q    <= s_axis_tdata;
            state_q <= ST_LOAD;
          end else if (s_axis_tuser == KIND_FETCH && pend_q) begin
            state_q <= ST_FADDR;
          end
        end
        ST_LOAD: begin
          if (prev_valid_q && prev_rd_q != px_q) begin
            any_q <= 1'b1;
            if (lx_q < minx_q) minx_q <= lx_q;
            if (lx_q > maxx_q) maxx_q <= lx_q;
            if (ly_q < miny_q) miny_q <= ly_q;
            if (ly_q > maxy_q) maxy_q <= ly_q;
          end
          lpos_q <= lpos_q + 1'b1;
          if (lx_q == fw_q - 1'b1) begin
            lx_q <= '0; ly_q <= ly_q + 1'b1;
          end else begin
            lx_q <= lx_q + 1'b1;
          end
          state_q <= sc_scan ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: if (sc_done && out_free) begin
          if (diff_en_q && prev_valid_q && any_q) begin
            sum_q.left    <= 9'(minx_q);
            sum_q.top     <= 9'(miny_q);
            sum_q.width   <= 10'(maxx_q - minx_q + 1'b1);
            sum_q.height  <= 10'(maxy_q - miny_q + 1'b1);
            sum_q.trans   <= trans_en_q;
            sum_q.tidx    <= trans_en_q ? sc_best : 8'd0;
            odata_q <= {8'd0, (trans_en_q ? sc_best : 8'd0), trans_en_q, any_q,
                        10'(maxy_q - miny_q + 1'b1), 10'(maxx_q - minx_q + 1'b1),
                        9'(miny_q), 9'(minx_q)};
            eaddr_q <= AW'(miny_q * fw_q + minx_q);
          end else begin
            sum_q.left <= '0; sum_q.top <= '0;
            sum_q.width <= 10'(fw_q); sum_q.height <= 10'(fh_q);
            sum_q.trans <= 1'b0; sum_q.tidx <= '0;
            odata_q <= {8'd0, 8'd0, 1'b0, any_q, 10'(fh_q), 10'(fw_q), 9'd0, 9'd0};
            eaddr_q <= '0;
          end
          sum_q.changed <= any_q;
          sfw_q   <= fw_q;
          ouser_q <= RES_SUMMARY; olast_q <= 1'b0; ovalid_q <= 1'b1;
          prev_valid_q <= diff_en_q;
          pend_q <= 1'b1;
          ex_q <= '0; ey_q <= '0;
          lpos_q <= '0; lx_q <= '0; ly_q <= '0;
          minx_q <= fw_q; maxx_q <= '0; miny_q <= fh_q; maxy_q <= '0; any_q <= 1'b0;
          state_q <= ST_IDLE;
        end
        ST_FADDR: begin
          elast_q <= (XW'(ex_q + 1'b1) == XW'(sum_q.width)) &&
                     (YW'(ey_q + 1'b1) == YW'(sum_q.height));
          state_q <= ST_FREAD;
        end
        ST_FREAD: state_q <= ST_FOUT;
        ST_FOUT: if (out_free) begin
          odata_q <= {((sum_q.trans && prev_rd_q == cur_rd_q) ? sum_q.tidx : cur_rd_q),
                      sum_q.tidx, sum_q.trans, sum_q.changed, sum_q.height,
                      sum_q.width, sum_q.top, sum_q.left};
          ouser_q <= RES_PIXEL; olast_q <= elast_q; ovalid_q <= 1'b1;
          if (elast_q) begin
            pend_q <= 1'b0; bank_q <= ~bank_q;
          end else if (XW'(ex_q + 1'b1) == XW'(sum_q.width)) begin
            ex_q <= '0; ey_q <= ey_q + 1'b1;
            eaddr_q <= AW'(eaddr_q + sfw_q - XW'(sum_q.width) + 1'b1);
          end else begin
            ex_q <= ex_q + 1'b1; eaddr_q <= eaddr_q + 1'b1;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign m_axis_tlast  = olast_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && !m_axis_tready) |=> ovalid_q && $stable(odata_q))
    else $error("result dropped under stall");
  a_scan_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> !pend_q) else $error("frame end while emitting");
  a_last_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && olast_q) |-> ouser_q == RES_PIXEL) else $error("tlast on summary");
  a_lpos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> lpos_q < total) else $error("load position past frame");
endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ifdr_pkg::*;

  localparam int unsigned MaxW      = 512;
  localparam int unsigned MaxH      = 512;
  localparam int unsigned StoreSize = MaxW * MaxH;
  localparam int unsigned CountSat  = 32'h7FFFF;
  localparam int unsigned DrainWait = 320;

  // Pending input item and expected result.
  typedef struct {
    kind_e      kind;
    logic [7:0] px;
  } pixel_item_t;

  typedef struct {
    res_kind_e  kind;
    summary_t   sum;
    logic [7:0] px;
    logic       last;
  } region_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_data_i = '0;

  pixel_item_t    pixel_q[$];
  region_result_t region_q[$];
  int             err_cnt = 0;
  bit             idle_on = 1'b1;
  int             send_gap = 0;
  int             recv_gap = 0;

  // Shadow state of the block.
  int unsigned fw, fh, diff_en, trans_en, prev_valid, any_chg, emit_pend;
  int unsigned ld_pos, em_pos, bank, bx0, bx1, by0, by1, lat_stride;
  int unsigned use_cnt[256];
  byte unsigned frame_mem[2][StoreSize];
  summary_t    lat;

  // Content of the last generated frame, used to derive similar frames.
  byte unsigned gen_prev[StoreSize];
  int          rand_items = 0;

  indexed_frame_delta_region uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    int r;
    if (!idle_on) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_size(logic [9:0] v, int unsigned maxv);
    int unsigned s;
    s = 32'(v);
    if (s == 0) begin
      s = 1;
    end
    if (s > maxv) begin
      s = maxv;
    end
    return s;
  endfunction

  function automatic void start_frame();
    foreach (use_cnt[i]) begin
      use_cnt[i] = 0;
    end
    ld_pos  = 0;
    bx0     = fw;
    bx1     = 0;
    by0     = fh;
    by1     = 0;
    any_chg = 0;
  endfunction

  function automatic void model_reset();
    bank       = 0;
    prev_valid = 0;
    emit_pend  = 0;
    em_pos     = 0;
    diff_en    = 0;
    trans_en   = 0;
    fw         = MaxW;
    fh         = MaxH;
    lat        = '0;
    lat.width  = 10'(fw);
    lat.height = 10'(fh);
    lat_stride = fw;
    start_frame();
  endfunction

  function automatic void model_config(logic [1:0] idx, logic [9:0] val);
    int unsigned s;
    case (idx)
      REG_DIFF_ENABLE: begin
        diff_en = 32'(val[0]);
      end
      REG_TRANSPARENT: begin
        trans_en = 32'(val[0]);
      end
      default: begin
        s = clamp_size(val, (idx == REG_FRAME_WIDTH) ? MaxW : MaxH);
        if (idx == REG_FRAME_WIDTH && s != fw) begin
          fw = s;
        end else if (idx == REG_FRAME_HEIGHT && s != fh) begin
          fh = s;
        end else begin
          return;
        end
        prev_valid = 0;
        start_frame();
      end
    endcase
  endfunction

  // Least-used palette index, lowest index on ties.
  function automatic logic [7:0] least_used_index();
    int unsigned best, lo;
    best = 0;
    lo   = 32'hFFFF_FFFF;
    for (int i = 0; i < 256; i++) begin
      if (use_cnt[i] < lo) begin
        lo   = use_cnt[i];
        best = i;
      end
    end
    return best[7:0];
  endfunction

  // Advance the shadow state by one accepted item; got is set when a result follows.
  function automatic void region_step(pixel_item_t it, output bit got,
                                      output region_result_t r);
    int unsigned total, x, y, src, dx, dy;
    bit          crop;
    got    = 1'b0;
    r      = '{RES_SUMMARY, '0, '0, 1'b0};
    if (it.kind == KIND_LOAD) begin
      if (emit_pend != 0) begin
        return;
      end
      total = fw * fh;
      if (ld_pos >= total) begin
        start_frame();
      end
      x = ld_pos % fw;
      y = ld_pos / fw;
      frame_mem[bank][ld_pos] = it.px;
      if (prev_valid != 0 && frame_mem[bank ^ 1][ld_pos] != it.px) begin
        any_chg = 1;
        if (x < bx0) bx0 = x;
        if (x > bx1) bx1 = x;
        if (y < by0) by0 = y;
        if (y > by1) by1 = y;
      end
      if (use_cnt[it.px] < CountSat) begin
        use_cnt[it.px]++;
      end
      ld_pos++;
      if (ld_pos < total) begin
        return;
      end
      // Frame end: latch the summary of the region to emit.
      crop        = (diff_en != 0) && (prev_valid != 0) && (any_chg != 0);
      lat.changed = any_chg[0];
      lat_stride  = fw;
      if (crop) begin
        lat.left   = 9'(bx0);
        lat.top    = 9'(by0);
        lat.width  = 10'(bx1 - bx0 + 1);
        lat.height = 10'(by1 - by0 + 1);
        lat.trans  = trans_en[0];
      end else begin
        lat.left   = '0;
        lat.top    = '0;
        lat.width  = 10'(fw);
        lat.height = 10'(fh);
        lat.trans  = 1'b0;
      end
      lat.tidx   = lat.trans ? least_used_index() : 8'd0;
      prev_valid = diff_en;
      emit_pend  = 1;
      em_pos     = 0;
      got        = 1'b1;
      r.sum      = lat;
      start_frame();
    end else begin
      if (emit_pend == 0) begin
        return;
      end
      total = lat.width * lat.height;
      dx    = em_pos % lat.width;
      dy    = em_pos / lat.width;
      src   = (lat.top + dy) * lat_stride + lat.left + dx;
      if (src >= StoreSize) begin
        src = 0;
      end
      r.kind = RES_PIXEL;
      r.sum  = lat;
      r.px   = frame_mem[bank][src];
      if (lat.trans && frame_mem[bank ^ 1][src] == frame_mem[bank][src]) begin
        r.px = lat.tidx;
      end
      r.last = (em_pos + 1 >= total);
      got    = 1'b1;
      if (r.last) begin
        emit_pend = 0;
        em_pos    = 0;
        bank      = bank ^ 1;
      end else begin
        em_pos++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    err_cnt++;
  endtask

  // Sender: one item per transfer, random gaps between items.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_item_t it;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        it            = pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= it.px;
        send_gap      <= draw_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls on the result side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else if (recv_gap > 0) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= recv_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) begin
        recv_gap <= draw_gap();
      end
    end
  end

  // Monitor: predict on input transfers, check on output transfers.
  always @(posedge clk_i) begin
    pixel_item_t    it;
    region_result_t r;
    bit             got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        it.kind = kind_e'(s_axis_tuser);
        it.px   = s_axis_tdata;
        region_step(it, got, r);
        if (got) begin
          region_q.insert(region_q.size(), r);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (region_q.size() == 0) begin
          $display("[%0t] result transfer with no expected result", $time);
          err_cnt++;
        end else begin
          r = region_q.pop_front();
          if (m_axis_tuser !== r.kind)
            report_mismatch("result_kind", m_axis_tuser, r.kind);
          if (m_axis_tdata[8:0] !== r.sum.left)
            report_mismatch("region_left", m_axis_tdata[8:0], r.sum.left);
          if (m_axis_tdata[17:9] !== r.sum.top)
            report_mismatch("region_top", m_axis_tdata[17:9], r.sum.top);
          if (m_axis_tdata[27:18] !== r.sum.width)
            report_mismatch("region_width", m_axis_tdata[27:18], r.sum.width);
          if (m_axis_tdata[37:28] !== r.sum.height)
            report_mismatch("region_height", m_axis_tdata[37:28], r.sum.height);
          if (m_axis_tdata[38] !== r.sum.changed)
            report_mismatch("frame_changed", m_axis_tdata[38], r.sum.changed);
          if (m_axis_tdata[39] !== r.sum.trans)
            report_mismatch("transparency_on", m_axis_tdata[39], r.sum.trans);
          if (m_axis_tdata[47:40] !== r.sum.tidx)
            report_mismatch("transparent_index", m_axis_tdata[47:40], r.sum.tidx);
          if (m_axis_tdata[55:48] !== r.px)
            report_mismatch("pixel_value", m_axis_tdata[55:48], r.px);
          if (m_axis_tlast !== r.last)
            report_mismatch("last_pixel", m_axis_tlast, r.last);
        end
      end
    end
  end

  task automatic cfg_write(logic [1:0] idx, logic [9:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    model_config(idx, val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Hold off until every item is sent and every result is back, then let the block settle.
  task automatic wait_idle();
    do begin
      @(posedge clk_i);
    end while (pixel_q.size() != 0 || s_axis_tvalid || region_q.size() != 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic add_item(kind_e k, logic [7:0] px);
    pixel_item_t it;
    it.kind = k;
    it.px   = px;
    pixel_q.insert(pixel_q.size(), it);
  endtask

  // One frame of loads followed by enough fetches to drain its region.
  // nchg < 0 gives fresh random content, otherwise the last frame with nchg edits.
  task automatic push_frame(int nchg, bit noisy);
    int unsigned total, p;
    total = fw * fh;
    if (nchg < 0) begin
      for (p = 0; p < total; p++) gen_prev[p] = 8'($urandom_range(0, 255));
    end else begin
      for (int i = 0; i < nchg; i++) gen_prev[$urandom_range(0, total - 1)] = 8'($urandom);
    end
    if (noisy && $urandom_range(0, 3) == 0) begin
      add_item(KIND_FETCH, 8'($urandom));
    end
    for (p = 0; p < total; p++) add_item(KIND_LOAD, gen_prev[p]);
    // Loads that arrive while the region is being emitted are dropped.
    if (noisy && $urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) add_item(KIND_LOAD, 8'($urandom));
    end
    for (p = 0; p < total; p++) add_item(KIND_FETCH, 8'($urandom));
    rand_items += 2 * total;
  endtask

  initial begin
    int unsigned w, h;
    model_reset();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // Sizes written as zero act as one: single-pixel frames.
    cfg_write(REG_FRAME_WIDTH, 10'd0);
    cfg_write(REG_FRAME_HEIGHT, 10'd0);
    cfg_write(REG_DIFF_ENABLE, 10'd1);
    cfg_write(REG_TRANSPARENT, 10'd1);
    add_item(KIND_FETCH, 8'h00);
    add_item(KIND_LOAD, 8'hFF);
    add_item(KIND_LOAD, 8'h00);
    add_item(KIND_FETCH, 8'hFF);
    add_item(KIND_FETCH, 8'h00);
    add_item(KIND_LOAD, 8'hFF);
    add_item(KIND_FETCH, 8'h00);
    add_item(KIND_LOAD, 8'h5A);
    add_item(KIND_FETCH, 8'h00);
    wait_idle();

    // Random phases of small frames with random settings.
    rand_items = 0;
    while (rand_items < 690) begin
      idle_on = ($urandom_range(0, 4) != 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16) : $urandom_range(1, 6);
      cfg_write(REG_FRAME_WIDTH, 10'(w));
      cfg_write(REG_FRAME_HEIGHT, 10'(h));
      cfg_write(REG_DIFF_ENABLE, 10'($urandom_range(0, 4) != 0));
      cfg_write(REG_TRANSPARENT, 10'($urandom_range(0, 1)));
      push_frame(-1, 1'b1);
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 3))
          0: push_frame(0, 1'b1);
          1: push_frame(1, 1'b1);
          2: push_frame($urandom_range(2, 6), 1'b1);
          default: push_frame(-1, 1'b1);
        endcase
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4_000_000;
    $display("[%0t] timeout", $time);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
